>>> hdl/sfc_pkg.sv
// ============================================================================
// sfc_pkg
// Shared constants, codes and types of the sphere frustum cull block.
// ============================================================================
`default_nettype none

package sfc_pkg;

   // Plane stack geometry
   localparam int MAX_PLANES  = 32;
   localparam int BASE_PLANES = 6;
   localparam int PLANE_AW    = $clog2(MAX_PLANES);
   localparam int DEPTH_W     = 6;

   // Field widths
   localparam int CMD_W   = 3;
   localparam int MASK_W  = 32;
   localparam int WORD_W  = 32;
   localparam int TOL_W   = 16;
   localparam int PLANE_W = 4 * WORD_W;

   // Distance arithmetic: exact Q32.32 products, exact sum, floor to Q16.16
   localparam int FRAC_W = 16;
   localparam int PROD_W = 2 * WORD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int DIST_W = ACC_W - FRAC_W + 1;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 3'd0,
      CMD_PUSH  = 3'd1,
      CMD_POP   = 3'd2,
      CMD_MASK  = 3'd3,
      CMD_TEST  = 3'd4
   } sfc_cmd_type;

   // One stored plane: normal and constant, signed Q16.16
   typedef struct packed {
      logic signed [WORD_W-1:0] c;
      logic signed [WORD_W-1:0] nz;
      logic signed [WORD_W-1:0] ny;
      logic signed [WORD_W-1:0] nx;
   } sfc_plane_type;

   // Distance unit status toward the controller
   typedef struct packed {
      logic                     done;
      logic signed [DIST_W-1:0] distance;
   } sfc_dist_rsp_type;

   // Distance unit phases
   typedef enum logic [2:0] {
      DP_IDLE  = 3'd0,
      DP_MUL_X = 3'd1,
      DP_MUL_Y = 3'd2,
      DP_MUL_Z = 3'd3,
      DP_ACC   = 3'd4,
      DP_DIST  = 3'd5
   } sfc_dist_phase_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DIST = 2'd2
   } sfc_state_type;

endpackage

`default_nettype wire

>>> hdl/sfc_req_if.sv
// ============================================================================
// sfc_req_if
// Request channel: command, plane or sphere payload, valid/ready handshake.
// ============================================================================
`default_nettype none

interface sfc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [sfc_pkg::CMD_W-1:0]             cmd;
   logic [sfc_pkg::PLANE_AW-1:0]          plane_index;
   logic [sfc_pkg::MASK_W-1:0]            mask_in;
   logic signed [sfc_pkg::WORD_W-1:0]     vec_x;
   logic signed [sfc_pkg::WORD_W-1:0]     vec_y;
   logic signed [sfc_pkg::WORD_W-1:0]     vec_z;
   logic signed [sfc_pkg::WORD_W-1:0]     scalar;

   modport source (
      output valid, cmd, plane_index, mask_in, vec_x, vec_y, vec_z, scalar,
      input  ready
   );

   modport sink (
      input  valid, cmd, plane_index, mask_in, vec_x, vec_y, vec_z, scalar,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/sfc_rsp_if.sv
// ============================================================================
// sfc_rsp_if
// Response channel: visibility, mask and stack depth, valid/ready handshake.
// ============================================================================
`default_nettype none

interface sfc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           visible;
   logic [sfc_pkg::MASK_W-1:0]     mask_out;
   logic [sfc_pkg::DEPTH_W-1:0]    plane_count;

   modport source (
      output valid, visible, mask_out, plane_count,
      input  ready
   );

   modport sink (
      input  valid, visible, mask_out, plane_count,
      output ready
   );
endinterface

`default_nettype wire

>>> hdl/sfc_ram.sv
// ============================================================================
// sfc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
`default_nettype none

module sfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, hold data between reads
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/sfc_dist.sv
// ============================================================================
// sfc_dist
// Signed plane distance d = floor(N.C / 2^16) - c with one shared multiplier.
// ============================================================================
`default_nettype none

module sfc_dist (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire sfc_pkg::sfc_plane_type               plane,
   input  wire logic signed [sfc_pkg::WORD_W-1:0]    cx,
   input  wire logic signed [sfc_pkg::WORD_W-1:0]    cy,
   input  wire logic signed [sfc_pkg::WORD_W-1:0]    cz,
   output      sfc_pkg::sfc_dist_rsp_type            result
);

   sfc_pkg::sfc_dist_phase_type              phase_ff, phase_in;
   logic                                     done_ff, done_in;
   logic signed [sfc_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic signed [sfc_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic signed [sfc_pkg::DIST_W-1:0]        dist_ff, dist_in;
   logic signed [sfc_pkg::WORD_W-1:0]        op_a, op_b;
   logic signed [sfc_pkg::ACC_W-sfc_pkg::FRAC_W-1:0] acc_floor;

   // Floor of the exact sum to Q16.16
   assign acc_floor = $signed(acc_ff[sfc_pkg::ACC_W-1:sfc_pkg::FRAC_W]);

   // Sequence operands, accumulate each registered product in the following phase
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      op_a     = '0;
      op_b     = '0;
      acc_in   = acc_ff;
      dist_in  = dist_ff;
      case (phase_ff)
         sfc_pkg::DP_IDLE: begin
            if (start) begin
               phase_in = sfc_pkg::DP_MUL_X;
            end
         end
         sfc_pkg::DP_MUL_X: begin
            op_a     = plane.nx;
            op_b     = cx;
            acc_in   = '0;
            phase_in = sfc_pkg::DP_MUL_Y;
         end
         sfc_pkg::DP_MUL_Y: begin
            op_a     = plane.ny;
            op_b     = cy;
            acc_in   = acc_ff + sfc_pkg::ACC_W'(prod_ff);
            phase_in = sfc_pkg::DP_MUL_Z;
         end
         sfc_pkg::DP_MUL_Z: begin
            op_a     = plane.nz;
            op_b     = cz;
            acc_in   = acc_ff + sfc_pkg::ACC_W'(prod_ff);
            phase_in = sfc_pkg::DP_ACC;
         end
         sfc_pkg::DP_ACC: begin
            acc_in   = acc_ff + sfc_pkg::ACC_W'(prod_ff);
            phase_in = sfc_pkg::DP_DIST;
         end
         sfc_pkg::DP_DIST: begin
            dist_in  = sfc_pkg::DIST_W'(acc_floor) - sfc_pkg::DIST_W'(plane.c);
            done_in  = 1'b1;
            phase_in = sfc_pkg::DP_IDLE;
         end
         default: begin
            phase_in = sfc_pkg::DP_IDLE;
         end
      endcase
   end

   // Exact 32x32 signed product
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfc_pkg::DP_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      dist_ff <= dist_in;
   end

   assign result.done     = done_ff;
   assign result.distance = dist_ff;

endmodule

`default_nettype wire

>>> hdl/sphere_frustum_cull_top.sv
// ============================================================================
// sphere_frustum_cull_top
// Bounding-sphere culling against a stack of up to 32 masked planes.
// ============================================================================
// Usage:
//   req_ch carries one command per transfer: write plane, push plane, pop
//   plane, set mask or test sphere. rsp_ch returns exactly one result per
//   command: visibility, the active mask and the stack depth after it.
//   csr_we/csr_wdata load the zero tolerance; write it only while idle.
// Sequencing:
//   Write, push, pop, set mask, unknown codes and tests with a radius at or
//   below the tolerance finish in the transfer cycle; the result shows the
//   next cycle. A sphere test walks the stack from the top plane down: each
//   active plane is one plane-RAM read and three passes through the single
//   32x32 multiplier, then accumulate, floor and compare, while masked-out
//   planes are skipped. One command is in work at a time.
// Reset:
//   Depth six, mask zero, tolerance one, all plane slots read as zero until
//   written (per-slot valid bits). No clearing pass.
// Stall:
//   The result register holds while rsp_ch.ready is low; a new command is
//   taken in the cycle the pending result transfers.
// ============================================================================
`default_nettype none

module sphere_frustum_cull_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sfc_req_if.sink                          req_ch,
   sfc_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_we,
   input  wire logic [sfc_pkg::TOL_W-1:0]   csr_wdata
);

   sfc_pkg::sfc_state_type                  state_ff, state_in;
   logic [sfc_pkg::MASK_W-1:0]              act_mask_ff, act_mask_in;
   logic [sfc_pkg::DEPTH_W-1:0]             depth_ff, depth_in;
   logic [sfc_pkg::TOL_W-1:0]               tol_ff, tol_in;
   logic [sfc_pkg::MAX_PLANES-1:0]          valid_ff, valid_in;
   logic [sfc_pkg::DEPTH_W-1:0]             k_ff, k_in;
   logic [sfc_pkg::PLANE_AW-1:0]            pidx_ff, pidx_in;
   logic signed [sfc_pkg::WORD_W-1:0]       cx_ff, cx_in;
   logic signed [sfc_pkg::WORD_W-1:0]       cy_ff, cy_in;
   logic signed [sfc_pkg::WORD_W-1:0]       cz_ff, cz_in;
   logic signed [sfc_pkg::WORD_W-1:0]       rad_ff, rad_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic                                    rsp_vis_ff, rsp_vis_in;
   logic [sfc_pkg::MASK_W-1:0]              rsp_mask_ff, rsp_mask_in;
   logic [sfc_pkg::DEPTH_W-1:0]             rsp_count_ff, rsp_count_in;

   logic                                    req_xfer;
   logic                                    finish;
   logic                                    fin_vis;
   logic [sfc_pkg::DEPTH_W-1:0]             scan_k;
   logic [sfc_pkg::PLANE_AW-1:0]            scan_idx;
   logic                                    ram_we;
   logic [sfc_pkg::PLANE_AW-1:0]            ram_waddr;
   logic                                    ram_re;
   logic [sfc_pkg::PLANE_W-1:0]             ram_rdata;
   sfc_pkg::sfc_plane_type                  plane_wr;
   sfc_pkg::sfc_plane_type                  plane_rd;
   logic                                    dist_start;
   sfc_pkg::sfc_dist_rsp_type               dist_rsp;
   logic signed [sfc_pkg::DIST_W-1:0]       rad_pos;
   logic signed [sfc_pkg::DIST_W-1:0]       rad_neg;

   // Take a command only when idle and the result register is free
   assign req_ch.ready = (state_ff == sfc_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // Next plane below the current scan position
   assign scan_k   = k_ff - sfc_pkg::DEPTH_W'(1);
   assign scan_idx = scan_k[sfc_pkg::PLANE_AW-1:0];

   // Plane words to store
   assign plane_wr.nx = req_ch.vec_x;
   assign plane_wr.ny = req_ch.vec_y;
   assign plane_wr.nz = req_ch.vec_z;
   assign plane_wr.c  = req_ch.scalar;

   // Slots never written read as zero
   assign plane_rd = valid_ff[pidx_ff] ? sfc_pkg::sfc_plane_type'(ram_rdata) : '0;

   assign rad_pos = sfc_pkg::DIST_W'(rad_ff);
   assign rad_neg = -rad_pos;

   // Command decode, plane walk and result load
   always_comb begin
      state_in     = state_ff;
      act_mask_in  = act_mask_ff;
      depth_in     = depth_ff;
      tol_in       = tol_ff;
      valid_in     = valid_ff;
      k_in         = k_ff;
      pidx_in      = pidx_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rad_in       = rad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_vis_in   = rsp_vis_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_count_in = rsp_count_ff;
      finish       = 1'b0;
      fin_vis      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = req_ch.plane_index;
      ram_re       = 1'b0;
      dist_start   = 1'b0;

      if (csr_we) begin
         tol_in = csr_wdata;
      end

      case (state_ff)
         sfc_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (req_ch.cmd)
                  sfc_pkg::CMD_WRITE: begin
                     ram_we                        = 1'b1;
                     ram_waddr                     = req_ch.plane_index;
                     valid_in[req_ch.plane_index]  = 1'b1;
                     finish                        = 1'b1;
                  end
                  sfc_pkg::CMD_PUSH: begin
                     if (depth_ff < sfc_pkg::DEPTH_W'(sfc_pkg::MAX_PLANES)) begin
                        ram_we    = 1'b1;
                        ram_waddr = depth_ff[sfc_pkg::PLANE_AW-1:0];
                        valid_in[depth_ff[sfc_pkg::PLANE_AW-1:0]] = 1'b1;
                        depth_in  = depth_ff + sfc_pkg::DEPTH_W'(1);
                     end
                     finish = 1'b1;
                  end
                  sfc_pkg::CMD_POP: begin
                     if (depth_ff > sfc_pkg::DEPTH_W'(sfc_pkg::BASE_PLANES)) begin
                        depth_in = depth_ff - sfc_pkg::DEPTH_W'(1);
                     end
                     finish = 1'b1;
                  end
                  sfc_pkg::CMD_MASK: begin
                     act_mask_in = req_ch.mask_in;
                     finish      = 1'b1;
                  end
                  sfc_pkg::CMD_TEST: begin
                     if (req_ch.scalar > $signed({1'b0, tol_ff})) begin
                        cx_in    = req_ch.vec_x;
                        cy_in    = req_ch.vec_y;
                        cz_in    = req_ch.vec_z;
                        rad_in   = req_ch.scalar;
                        k_in     = depth_ff;
                        state_in = sfc_pkg::ST_SCAN;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end

         // Walk down the stack, skip masked-out planes
         sfc_pkg::ST_SCAN: begin
            if (k_ff == '0) begin
               fin_vis  = 1'b1;
               finish   = 1'b1;
               state_in = sfc_pkg::ST_IDLE;
            end else begin
               k_in = scan_k;
               if (act_mask_ff[scan_idx]) begin
                  ram_re     = 1'b1;
                  pidx_in    = scan_idx;
                  dist_start = 1'b1;
                  state_in   = sfc_pkg::ST_DIST;
               end
            end
         end

         // Compare distance against the radius
         sfc_pkg::ST_DIST: begin
            if (dist_rsp.done) begin
               if (dist_rsp.distance <= rad_neg) begin
                  fin_vis  = 1'b0;
                  finish   = 1'b1;
                  state_in = sfc_pkg::ST_IDLE;
               end else begin
                  if (dist_rsp.distance >= rad_pos) begin
                     act_mask_in[pidx_ff] = 1'b0;
                  end
                  state_in = sfc_pkg::ST_SCAN;
               end
            end
         end

         default: begin
            state_in = sfc_pkg::ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_vis_in   = fin_vis;
         rsp_mask_in  = act_mask_in;
         rsp_count_in = depth_in;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfc_pkg::ST_IDLE;
         act_mask_ff  <= '0;
         depth_ff     <= sfc_pkg::DEPTH_W'(sfc_pkg::BASE_PLANES);
         tol_ff       <= sfc_pkg::TOL_W'(1);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_mask_ff  <= act_mask_in;
         depth_ff     <= depth_in;
         tol_ff       <= tol_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      pidx_ff      <= pidx_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      rad_ff       <= rad_in;
      rsp_vis_ff   <= rsp_vis_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Plane store: writes only while idle, reads only while walking
   sfc_ram #(
      .WIDTH (sfc_pkg::PLANE_W),
      .DEPTH (sfc_pkg::MAX_PLANES)
   ) u_plane_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (plane_wr),
      .re    (ram_re),
      .raddr (scan_idx),
      .rdata (ram_rdata)
   );

   sfc_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .start  (dist_start),
      .plane  (plane_rd),
      .cx     (cx_ff),
      .cy     (cy_ff),
      .cz     (cz_ff),
      .result (dist_rsp)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.visible     = rsp_vis_ff;
   assign rsp_ch.mask_out    = rsp_mask_ff;
   assign rsp_ch.plane_count = rsp_count_ff;

endmodule

`default_nettype wire

>>> hdl/sfc_checker.sv
// ============================================================================
// sfc_checker
// Port-level assertions for the sphere frustum cull block, bound to the top.
// ============================================================================
`default_nettype none

module sfc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [sfc_pkg::CMD_W-1:0]      req_cmd,
   input wire logic [sfc_pkg::MASK_W-1:0]     req_mask_in,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_visible,
   input wire logic [sfc_pkg::MASK_W-1:0]     rsp_mask_out,
   input wire logic [sfc_pkg::DEPTH_W-1:0]    rsp_plane_count
);

   logic req_xfer;

   assign req_xfer = req_valid && req_ready;

   // Stack depth stays between the frustum planes and the full stack
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_plane_count >= sfc_pkg::DEPTH_W'(sfc_pkg::BASE_PLANES)) &&
                    (rsp_plane_count <= sfc_pkg::DEPTH_W'(sfc_pkg::MAX_PLANES)))
      else $error("plane_count out of range");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_visible) &&
                                  $stable(rsp_mask_out) && $stable(rsp_plane_count))
      else $error("stalled result changed");

   // Non-test commands answer in the next cycle, never visible
   a_non_test: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_cmd != sfc_pkg::CMD_TEST) |=> rsp_valid && !rsp_visible)
      else $error("non-test command result wrong");

   // Set mask shows the written mask
   a_set_mask: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_cmd == sfc_pkg::CMD_MASK) |=> rsp_mask_out == $past(req_mask_in))
      else $error("set mask result wrong");

endmodule

bind sphere_frustum_cull_top sfc_checker u_sfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_cmd         (req_ch.cmd),
   .req_mask_in     (req_ch.mask_in),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_visible     (rsp_ch.visible),
   .rsp_mask_out    (rsp_ch.mask_out),
   .rsp_plane_count (rsp_ch.plane_count)
);

`default_nettype wire

>>> verif/sphere_frustum_cull_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// sphere_frustum_cull_top_test
// Self-checking bench for the plane-stack sphere culler. Commands go in over
// req_ch with random gaps and the results are taken from rsp_ch under random
// stalls. A behavioral copy of the plane stack, the active mask and the zero
// tolerance works out each result as its command transfers. Every result is
// compared field by field in arrival order. Directed cases come first, then
// the stack limits, the tolerance extremes, random traffic, a long result
// stall, and a closing stretch without idling.
// ============================================================================

module sphere_frustum_cull_top_test;
   import sfc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam int ONE          = 65536;         // 1.0 in Q16.16
   localparam int WORLD_SPAN   = 1 << 22;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic [CMD_W-1:0] CMD_TOP_CODE = '1;
   localparam logic [TOL_W-1:0] TOL_RESET    = 16'd1;

   typedef struct {
      logic [CMD_W-1:0]           cmd;
      logic [PLANE_AW-1:0]        slot;
      logic [MASK_W-1:0]          mask;
      logic signed [WORD_W-1:0]   x;
      logic signed [WORD_W-1:0]   y;
      logic signed [WORD_W-1:0]   z;
      logic signed [WORD_W-1:0]   s;
   } cull_cmd_type;

   typedef struct {
      logic                 visible;
      logic [MASK_W-1:0]    mask;
      logic [DEPTH_W-1:0]   count;
   } cull_verdict_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [TOL_W-1:0] csr_wdata;

   sfc_req_if req_ch ();
   sfc_rsp_if rsp_ch ();

   // Shadow copy of the block state
   sfc_plane_type      shadow_planes [MAX_PLANES];
   logic [MASK_W-1:0]  shadow_mask  = '0;
   int                 shadow_depth = BASE_PLANES;
   logic [TOL_W-1:0]   shadow_tol   = TOL_RESET;

   cull_verdict_type verdicts_due [$];
   int  error_count     = 0;
   int  cycle_count     = 0;
   int  rsp_hold_cycles = 0;
   bit  idle_on         = 1'b1;

   sphere_frustum_cull_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic log_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Apply one command to the shadow state and return the result it gives
   function automatic cull_verdict_type apply_cull_command(cull_cmd_type c);
      cull_verdict_type   v;
      sfc_plane_type      p;
      logic signed [65:0] distance;
      logic signed [65:0] rad;
      int                 k;
      p.nx = c.x;
      p.ny = c.y;
      p.nz = c.z;
      p.c  = c.s;
      v.visible = 1'b0;
      case (c.cmd)
         CMD_WRITE: shadow_planes[c.slot] = p;
         CMD_PUSH: begin
            if (shadow_depth < MAX_PLANES) begin
               shadow_planes[shadow_depth] = p;
               shadow_depth++;
            end
         end
         CMD_POP: begin
            if (shadow_depth > BASE_PLANES) shadow_depth--;
         end
         CMD_MASK: shadow_mask = c.mask;
         CMD_TEST: begin
            if (longint'(c.s) > longint'(shadow_tol)) begin
               rad = 66'(c.s);
               v.visible = 1'b1;
               // walk from the top plane down, stop at the first culling plane
               for (k = shadow_depth - 1; k >= 0 && v.visible; k--) begin
                  if (shadow_mask[k]) begin
                     p = shadow_planes[k];
                     distance = longint'(p.nx) * longint'(c.x)
                              + longint'(p.ny) * longint'(c.y)
                              + longint'(p.nz) * longint'(c.z);
                     distance = (distance >>> FRAC_W) - p.c;
                     if (distance <= -rad) v.visible = 1'b0;
                     else if (distance >= rad) shadow_mask[k] = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
      v.mask  = shadow_mask;
      v.count = DEPTH_W'(shadow_depth);
      return v;
   endfunction

   function automatic cull_cmd_type make_cmd(logic [CMD_W-1:0] op,
                                             logic [PLANE_AW-1:0] slot,
                                             logic [MASK_W-1:0] mask,
                                             logic signed [WORD_W-1:0] x,
                                             logic signed [WORD_W-1:0] y,
                                             logic signed [WORD_W-1:0] z,
                                             logic signed [WORD_W-1:0] s);
      cull_cmd_type c;
      c.cmd  = op;
      c.slot = slot;
      c.mask = mask;
      c.x    = x;
      c.y    = y;
      c.z    = z;
      c.s    = s;
      return c;
   endfunction

   function automatic int spread(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly scene-scale geometry so that visible, culled and cleared all occur
   function automatic cull_cmd_type random_cmd();
      cull_cmd_type c;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)      c.cmd = CMD_TEST;
      else if (pick < 60) c.cmd = CMD_WRITE;
      else if (pick < 70) c.cmd = CMD_PUSH;
      else if (pick < 80) c.cmd = CMD_POP;
      else if (pick < 93) c.cmd = CMD_MASK;
      else                c.cmd = CMD_W'($urandom_range(CMD_TEST + 1, CMD_TOP_CODE));
      c.slot = PLANE_AW'($urandom_range(0, MAX_PLANES - 1));
      c.mask = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
      if ($urandom_range(0, 9) < 2) begin
         c.x = $urandom;
         c.y = $urandom;
         c.z = $urandom;
         c.s = $urandom;
      end else if (c.cmd == CMD_TEST) begin
         c.x = spread(WORLD_SPAN);
         c.y = spread(WORLD_SPAN);
         c.z = spread(WORLD_SPAN);
         c.s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * ONE)
                                           : $urandom_range(0, WORLD_SPAN);
      end else begin
         c.x = spread(ONE);
         c.y = spread(ONE);
         c.z = spread(ONE);
         c.s = spread(WORLD_SPAN);
      end
      return c;
   endfunction

   // Offer one command, hold it until it transfers, then predict its result
   task automatic issue_command(cull_cmd_type c);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c.cmd;
      req_ch.plane_index <= c.slot;
      req_ch.mask_in     <= c.mask;
      req_ch.vec_x       <= c.x;
      req_ch.vec_y       <= c.y;
      req_ch.vec_z       <= c.z;
      req_ch.scalar      <= c.s;
      do @(posedge clock); while (!req_ch.ready);
      verdicts_due.push_back(apply_cull_command(c));
   endtask

   task automatic drain_verdicts();
      req_ch.valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   task automatic load_tolerance(logic [TOL_W-1:0] value);
      drain_verdicts();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_tol = value;
   endtask

   task automatic test_directed_cases();
      int op;
      // empty mask: everything above the tolerance is visible
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, WORD_MAX));
      // radius at, below and far below the tolerance
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, 1));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, 0));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, WORD_MIN));
      // extreme plane in the lowest slot, unit planes elsewhere
      issue_command(make_cmd(CMD_WRITE, 0, '1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
      issue_command(make_cmd(CMD_WRITE, PLANE_AW'(MAX_PLANES - 1), 0, ONE, 0, 0, 0));
      issue_command(make_cmd(CMD_WRITE, 1, 0, ONE, 0, 0, 100 * ONE));
      issue_command(make_cmd(CMD_WRITE, 2, 0, -ONE, 0, 0, -100 * ONE));
      issue_command(make_cmd(CMD_PUSH, 0, 0, ONE, 0, 0, -100 * ONE));
      issue_command(make_cmd(CMD_MASK, 0, '1, 0, 0, 0, 0));
      // top and middle planes clear their bits, then plane 1 culls
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, ONE));
      issue_command(make_cmd(CMD_MASK, 0, '1, 0, 0, 0, 0));
      issue_command(make_cmd(CMD_TEST, 0, 0, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX));
      issue_command(make_cmd(CMD_TEST, 0, 0, WORD_MAX, WORD_MAX, WORD_MAX, 2));
      issue_command(make_cmd(CMD_MASK, 0, 0, 0, 0, 0, 0));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, ONE));
      issue_command(make_cmd(CMD_MASK, 0, 32'h0000_0041, 0, 0, 0, 0));
      issue_command(make_cmd(CMD_TEST, 0, 0, 5 * ONE, 0, 0, ONE));
      // pop down to the frustum planes, then once more at the floor
      issue_command(make_cmd(CMD_POP, 0, 0, 0, 0, 0, 0));
      issue_command(make_cmd(CMD_POP, 0, 0, 0, 0, 0, 0));
      // unused opcodes change nothing
      for (op = CMD_TEST + 1; op <= CMD_TOP_CODE; op++)
         issue_command(make_cmd(CMD_W'(op), PLANE_AW'($urandom), $urandom, $urandom,
                                $urandom, $urandom, $urandom));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, WORD_MAX));
   endtask

   task automatic test_stack_limits();
      cull_cmd_type c;
      // fill the stack, then push into a full stack
      while (shadow_depth < MAX_PLANES) begin
         c = random_cmd();
         c.cmd = CMD_PUSH;
         issue_command(c);
      end
      repeat (2) begin
         c = random_cmd();
         c.cmd = CMD_PUSH;
         issue_command(c);
      end
      issue_command(make_cmd(CMD_MASK, 0, '1, 0, 0, 0, 0));
      repeat (4) begin
         c = random_cmd();
         c.cmd = CMD_TEST;
         issue_command(c);
      end
      // unwind to the base, with a test now and then
      while (shadow_depth > BASE_PLANES) begin
         c = random_cmd();
         c.cmd = ($urandom_range(0, 3) == 0) ? CMD_TEST : CMD_POP;
         issue_command(c);
      end
      issue_command(make_cmd(CMD_POP, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_tolerance_extremes();
      issue_command(make_cmd(CMD_MASK, 0, 0, 0, 0, 0, 0));
      load_tolerance('0);
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, 0));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, 1));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, -1));
      load_tolerance('1);
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, ONE - 1));
      issue_command(make_cmd(CMD_TEST, 0, 0, 0, 0, 0, ONE));
   endtask

   task automatic test_random_mix();
      repeat (4) begin
         load_tolerance(TOL_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, ONE - 1)
                                                           : $urandom_range(0, 64)));
         repeat (150) issue_command(random_cmd());
      end
   endtask

   // Stall the result side long enough that the request side backs up
   task automatic test_result_backpressure();
      rsp_hold_cycles = 400;
      repeat (30) issue_command(random_cmd());
   endtask

   task automatic test_steady_stream();
      load_tolerance(TOL_RESET);
      idle_on = 1'b0;
      repeat (100) issue_command(random_cmd());
   endtask

   // Result side ready: random stall bursts plus requested long hold-offs
   initial begin
      int stall;
      forever begin
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      cull_verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (verdicts_due.size() == 0) begin
            log_error("result transfer with no command outstanding");
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_ch.visible !== want.visible)
               log_error($sformatf("visible got %0b want %0b",
                                   rsp_ch.visible, want.visible));
            if (rsp_ch.mask_out !== want.mask)
               log_error($sformatf("mask_out got %h want %h",
                                   rsp_ch.mask_out, want.mask));
            if (rsp_ch.plane_count !== want.count)
               log_error($sformatf("plane_count got %0d want %0d",
                                   rsp_ch.plane_count, want.count));
         end
      end
   end

   initial begin
      foreach (shadow_planes[i]) shadow_planes[i] = '0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_WRITE;
      req_ch.plane_index <= '0;
      req_ch.mask_in     <= '0;
      req_ch.vec_x       <= '0;
      req_ch.vec_y       <= '0;
      req_ch.vec_z       <= '0;
      req_ch.scalar      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_stack_limits();
      test_tolerance_extremes();
      test_random_mix();
      test_result_backpressure();
      test_steady_stream();

      // let the last results arrive and watch for strays
      drain_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
